[src/stu_pkg.sv]
// Shared types, constants and helpers for the string-to-unsigned parser.
// Used by stu_char_decode, stu_step and string_to_unsigned_parser.
`timescale 1ns / 1ps

package stu_pkg;

  // Width of the saturating consumed-character counter.
  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Field widths of the channels.
  localparam int CH_BITS    = 8;
  localparam int BASE_BITS  = 6;
  localparam int VALUE_BITS = 32;
  localparam int POS_BITS   = 16;

  // Characters with a special meaning.
  localparam logic [CH_BITS-1:0] CH_NUL  = 8'h00;
  localparam logic [CH_BITS-1:0] CH_ZERO = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE = 8'h39;
  localparam logic [CH_BITS-1:0] CH_LA   = 8'h61;
  localparam logic [CH_BITS-1:0] CH_LZ   = 8'h7a;
  localparam logic [CH_BITS-1:0] CH_UA   = 8'h41;
  localparam logic [CH_BITS-1:0] CH_UZ   = 8'h5a;
  localparam logic [CH_BITS-1:0] CH_X    = 8'h78;
  localparam logic [CH_BITS-1:0] CH_O    = 8'h6f;

  // Bases.
  localparam logic [BASE_BITS-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX = 6'd16;
  localparam logic [BASE_BITS-1:0] BASE_OCT = 6'd8;

  // Letters are worth ten and up.
  localparam logic [BASE_BITS-1:0] LETTER_OFFSET = 6'd10;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_RANGE   = 2'd3;

  // Classification of one character.
  typedef struct packed {
    logic                 is_nul;
    logic                 is_alnum;
    logic                 is_zero;
    logic                 is_x;
    logic                 is_o;
    logic [BASE_BITS-1:0] digit;
  } char_info_t;

  // One result item as it leaves the step logic.
  typedef struct packed {
    logic                  emit;
    logic [VALUE_BITS-1:0] value;
    logic [1:0]            status;
    logic [POS_BITS-1:0]   pos;
  } result_t;

  // The reported position is the counter taken modulo 2^16.
  function automatic logic [POS_BITS-1:0] count_to_pos(input logic [COUNT_BITS-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[POS_BITS-1:0];
  endfunction

endpackage

[src/stu_char_decode.sv]
// Character classifier: flags special characters and gives the digit worth.
// Depends on stu_pkg.
`timescale 1ns / 1ps

module stu_char_decode (
  input  logic [stu_pkg::CH_BITS-1:0] ch,
  output stu_pkg::char_info_t         info
);

  logic                          is_num;
  logic                          is_lower;
  logic                          is_upper;
  logic [stu_pkg::CH_BITS-1:0]   diff;

  // Range checks for the three digit groups.
  assign is_num   = (ch >= stu_pkg::CH_ZERO) && (ch <= stu_pkg::CH_NINE);
  assign is_lower = (ch >= stu_pkg::CH_LA) && (ch <= stu_pkg::CH_LZ);
  assign is_upper = (ch >= stu_pkg::CH_UA) && (ch <= stu_pkg::CH_UZ);

  // Offset from the start of the matching group.
  always_comb begin
    priority if (is_lower) begin
      diff = ch - stu_pkg::CH_LA;
    end else if (is_upper) begin
      diff = ch - stu_pkg::CH_UA;
    end else begin
      diff = ch - stu_pkg::CH_ZERO;
    end
  end

  // Pack the classification; digit is meaningful only for alphanumerics.
  always_comb begin
    info.is_nul   = (ch == stu_pkg::CH_NUL);
    info.is_alnum = is_num || is_lower || is_upper;
    info.is_zero  = (ch == stu_pkg::CH_ZERO);
    info.is_x     = (ch == stu_pkg::CH_X);
    info.is_o     = (ch == stu_pkg::CH_O);
    if (is_num) begin
      info.digit = diff[stu_pkg::BASE_BITS-1:0];
    end else begin
      info.digit = diff[stu_pkg::BASE_BITS-1:0] + stu_pkg::LETTER_OFFSET;
    end
  end

endmodule

[src/stu_step.sv]
// Parser state and the per-character update: one multiply-add per character.
// Depends on stu_pkg; fed by stu_char_decode.
`timescale 1ns / 1ps

module stu_step (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  stu_pkg::char_info_t           info,
  input  logic [stu_pkg::BASE_BITS-1:0] req_base,
  output stu_pkg::result_t              res
);

  logic [stu_pkg::VALUE_BITS-1:0] accumulator;
  logic [stu_pkg::VALUE_BITS-1:0] accumulator_next;
  logic [stu_pkg::BASE_BITS-1:0]  current_base;
  logic [stu_pkg::BASE_BITS-1:0]  current_base_next;
  logic [stu_pkg::COUNT_BITS-1:0] char_count;
  logic [stu_pkg::COUNT_BITS-1:0] char_count_next;
  logic                           leading_zero_seen;
  logic                           leading_zero_seen_next;
  logic                           discarding;
  logic                           discarding_next;

  logic [stu_pkg::BASE_BITS-1:0]  start_base;
  logic [stu_pkg::BASE_BITS-1:0]  eff_base;
  logic                           first;
  logic                           second;
  logic [stu_pkg::COUNT_BITS-1:0] count_inc;
  logic [stu_pkg::VALUE_BITS-1:0] product;

  // The base is latched from the register at the first character.
  assign start_base = (req_base == '0) ? stu_pkg::BASE_DEC : req_base;
  assign first      = (char_count == '0);
  assign second     = (char_count == {{(stu_pkg::COUNT_BITS-1){1'b0}}, 1'b1});
  assign eff_base   = first ? start_base : current_base;
  assign count_inc  = (char_count == stu_pkg::COUNT_MAX) ? char_count : char_count + 1'b1;
  assign product    = accumulator * {{(stu_pkg::VALUE_BITS-stu_pkg::BASE_BITS){1'b0}}, eff_base};

  // Next state and result for the character in the input register.
  always_comb begin
    accumulator_next       = accumulator;
    current_base_next      = eff_base;
    char_count_next        = char_count;
    leading_zero_seen_next = leading_zero_seen;
    discarding_next        = discarding;
    res.emit               = 1'b0;
    res.value              = accumulator;
    res.status             = stu_pkg::ST_OK;
    res.pos                = stu_pkg::count_to_pos(char_count);

    priority if (discarding) begin
      // Skip everything up to the terminator, which starts a new string.
      current_base_next = current_base;
      if (info.is_nul) begin
        accumulator_next       = '0;
        current_base_next      = start_base;
        char_count_next        = '0;
        leading_zero_seen_next = 1'b0;
        discarding_next        = 1'b0;
      end
    end else if (info.is_nul) begin
      res.emit               = 1'b1;
      res.status             = first ? stu_pkg::ST_EMPTY : stu_pkg::ST_OK;
      accumulator_next       = '0;
      current_base_next      = start_base;
      char_count_next        = '0;
      leading_zero_seen_next = 1'b0;
    end else if (first && info.is_zero) begin
      leading_zero_seen_next = 1'b1;
      char_count_next        = count_inc;
    end else if (leading_zero_seen && second && (info.is_x || info.is_o)) begin
      // Prefix after a leading zero selects hex or octal.
      current_base_next = info.is_x ? stu_pkg::BASE_HEX : stu_pkg::BASE_OCT;
      char_count_next   = count_inc;
    end else if (!info.is_alnum) begin
      res.emit        = 1'b1;
      res.status      = stu_pkg::ST_INVALID;
      discarding_next = 1'b1;
    end else if (info.digit >= eff_base) begin
      res.emit        = 1'b1;
      res.status      = stu_pkg::ST_RANGE;
      discarding_next = 1'b1;
    end else begin
      accumulator_next = product + {{(stu_pkg::VALUE_BITS-stu_pkg::BASE_BITS){1'b0}}, info.digit};
      char_count_next  = count_inc;
    end
  end

  // State registers advance only when a character is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator       <= '0;
      current_base      <= stu_pkg::BASE_DEC;
      char_count        <= '0;
      leading_zero_seen <= 1'b0;
      discarding        <= 1'b0;
    end else if (en) begin
      accumulator       <= accumulator_next;
      current_base      <= current_base_next;
      char_count        <= char_count_next;
      leading_zero_seen <= leading_zero_seen_next;
      discarding        <= discarding_next;
    end
  end

`ifndef SYNTHESIS
  // While skipping after an error no result may be produced.
  assert property (@(posedge clk) disable iff (rst) (en && discarding) |-> !res.emit)
    else $error("result produced while discarding");

  // An error result always switches the parser into discarding.
  assert property (@(posedge clk) disable iff (rst)
    (en && res.emit && (res.status == stu_pkg::ST_INVALID || res.status == stu_pkg::ST_RANGE))
    |=> discarding)
    else $error("error result without discarding");
`endif

endmodule

[src/string_to_unsigned_parser.sv]
// Top level of the streaming string-to-unsigned parser: channel registers,
// base register and instances. Depends on stu_pkg, stu_char_decode, stu_step.
`timescale 1ns / 1ps

//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+---------------------------------
//  input    | in        | in_valid / in_stall  | ch[7:0]
//  result   | out       | out_valid / out_stall| value[31:0] status[1:0] end_position[15:0]
//  config   | in        | cfg_valid / cfg_ready| cfg_data[5:0] (requested base)
//
// One character is taken every cycle unless a result is stalled; a result is
// registered from its terminating or offending character in the input register.
// The rate is set by the one 32x6 multiply-add on the accumulator per character.
// Reset is synchronous and clears all control state; the base register resets to 0.
// A stalled result holds the output register and stalls the input register behind it.

module string_to_unsigned_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [stu_pkg::CH_BITS-1:0]    ch,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [stu_pkg::VALUE_BITS-1:0] value,
  output logic [1:0]                     status,
  output logic [stu_pkg::POS_BITS-1:0]   end_position,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stu_pkg::BASE_BITS-1:0]  cfg_data
);

  logic [stu_pkg::BASE_BITS-1:0] req_base;
  logic [stu_pkg::CH_BITS-1:0]   ch_reg;
  logic                          ch_valid;
  logic                          adv;
  logic                          load;
  logic                          process;
  stu_pkg::char_info_t           info;
  stu_pkg::result_t              res;

  // The base register accepts a write in any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_base <= '0;
    end else if (cfg_valid && cfg_ready) begin
      req_base <= cfg_data;
    end
  end

  // Pipeline moves unless a result waits on a stalled receiver.
  assign adv      = !(out_valid && out_stall);
  assign load     = !ch_valid || adv;
  assign in_stall = !load;
  assign process  = ch_valid && adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= 1'b0;
    end else if (load) begin
      ch_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      ch_reg <= ch;
    end
  end

  stu_char_decode u_decode (
    .ch   (ch_reg),
    .info (info)
  );

  stu_step u_step (
    .clk      (clk),
    .rst      (rst),
    .en       (process),
    .info     (info),
    .req_base (req_base),
    .res      (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= process && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (process && res.emit) begin
      value        <= res.value;
      status       <= res.status;
      end_position <= res.pos;
    end
  end

`ifndef SYNTHESIS
  // The input side stalls only behind a held result.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // A new result needs a character in the input register the cycle before.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid && out_stall)) |-> $past(ch_valid))
    else $error("result without a processed character");
`endif

endmodule
